FILE: rtl/core/uart_dual_ring_buffer_assert.svh
// Assertion macros for the dual UART ring buffer block.
`ifndef UART_DUAL_RING_BUFFER_ASSERT_SVH
`define UART_DUAL_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UADRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UADRB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

FILE: rtl/core/uadrb_pkg.sv
// Shared types and constants for the dual UART ring buffer block.
package uadrb_pkg;

  localparam int RX_DEPTH_DEF   = 16;
  localparam int TX_DEPTH_DEF   = 16;
  localparam int PORT_COUNT_DEF = 2;

  typedef enum logic [2:0] {
    CMD_TX_WRITE = 3'd0,
    CMD_RX_READ  = 3'd1,
    CMD_LINE_RX  = 3'd2,
    CMD_LINE_TX  = 3'd3,
    CMD_LINE_ERR = 3'd4,
    CMD_INIT     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0] command;
    logic       port_sel;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status_code;
    logic [7:0] read_byte;
    logic       line_tx_valid;
    logic [7:0] line_tx_byte;
    logic       tx_irq_on;
    logic [4:0] rx_level;
    logic [4:0] tx_level;
    logic       rx_overflow_flag;
    logic       line_error_flag;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } ctrl_t;

endpackage

FILE: rtl/core/uadrb_ctrl.sv
// Sequencing state machine: accept, execute, respond.
module uadrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output uadrb_pkg::ctrl_t  ctrl
);

  uadrb_pkg::state_t state_r;
  uadrb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uadrb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uadrb_pkg::S_IDLE: begin
        if (start) state_nxt = uadrb_pkg::S_EXEC;
      end
      uadrb_pkg::S_EXEC: begin
        state_nxt = uadrb_pkg::S_RESP;
      end
      uadrb_pkg::S_RESP: begin
        state_nxt = start ? uadrb_pkg::S_EXEC : uadrb_pkg::S_IDLE;
      end
      default: begin
        state_nxt = uadrb_pkg::S_IDLE;
      end
    endcase
  end

  // The response cycle only drives registered results, so a new item may enter then.
  always_comb begin
    busy      = (state_r == uadrb_pkg::S_EXEC);
    ctrl.load = start && !busy;
    ctrl.exec = (state_r == uadrb_pkg::S_EXEC);
    ctrl.resp = (state_r == uadrb_pkg::S_RESP);
  end

endmodule

FILE: rtl/core/uadrb_dpath.sv
// Ring pointers, counters, flags, byte memories and result register.
module uadrb_dpath #(
  parameter int RX_DEPTH   = uadrb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH   = uadrb_pkg::TX_DEPTH_DEF,
  parameter int PORT_COUNT = uadrb_pkg::PORT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uadrb_pkg::ctrl_t     ctrl,
  input  uadrb_pkg::in_item_t  in_item,
  output uadrb_pkg::out_item_t out_item
);

  localparam int PW  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam int RFW = $clog2(RX_DEPTH + 1);
  localparam int TFW = $clog2(TX_DEPTH + 1);
  localparam int RAW = $clog2(PORT_COUNT * RX_DEPTH);
  localparam int TAW = $clog2(PORT_COUNT * TX_DEPTH);

  uadrb_pkg::in_item_t item_r;

  logic [RPW-1:0] rx_head_r [PORT_COUNT];
  logic [RPW-1:0] rx_tail_r [PORT_COUNT];
  logic [RFW-1:0] rx_fill_r [PORT_COUNT];
  logic [TPW-1:0] tx_head_r [PORT_COUNT];
  logic [TPW-1:0] tx_tail_r [PORT_COUNT];
  logic [TFW-1:0] tx_fill_r [PORT_COUNT];
  logic           irq_r     [PORT_COUNT];
  logic           ovf_r     [PORT_COUNT];
  logic           err_r     [PORT_COUNT];

  logic [7:0] rx_mem [PORT_COUNT * RX_DEPTH];
  logic [7:0] tx_mem [PORT_COUNT * TX_DEPTH];
  logic [7:0] rx_q_r;
  logic [7:0] tx_q_r;

  uadrb_pkg::out_item_t res_r;
  uadrb_pkg::out_item_t res_nxt;
  logic                 rd_ok_r;

  logic           port_ok;
  logic [PW-1:0]  pidx;
  logic [RPW-1:0] rx_h, rx_t, rx_h_nxt, rx_t_nxt;
  logic [RFW-1:0] rx_f, rx_f_nxt;
  logic [TPW-1:0] tx_h, tx_t, tx_h_nxt, tx_t_nxt;
  logic [TFW-1:0] tx_f, tx_f_nxt;
  logic           irq_nxt, ovf_nxt, err_nxt;
  logic           rx_we, rx_re, tx_we, tx_re, rd_ok, txv;
  uadrb_pkg::status_t st;
  logic [RAW-1:0] rx_waddr, rx_raddr;
  logic [TAW-1:0] tx_waddr, tx_raddr;
  logic [RFW+4:0] rx_lvl_ext;
  logic [TFW+4:0] tx_lvl_ext;
  logic           do_upd;

  always_ff @(posedge clk) begin
    if (ctrl.load) item_r <= in_item;
  end

  always_comb begin
    port_ok = (32'(item_r.port_sel) < PORT_COUNT);
    pidx    = PW'(item_r.port_sel);
    rx_h    = rx_head_r[pidx];
    rx_t    = rx_tail_r[pidx];
    rx_f    = rx_fill_r[pidx];
    tx_h    = tx_head_r[pidx];
    tx_t    = tx_tail_r[pidx];
    tx_f    = tx_fill_r[pidx];
  end

  // Next state of the addressed port for the latched command.
  always_comb begin
    rx_h_nxt = rx_h;
    rx_t_nxt = rx_t;
    rx_f_nxt = rx_f;
    tx_h_nxt = tx_h;
    tx_t_nxt = tx_t;
    tx_f_nxt = tx_f;
    irq_nxt  = irq_r[pidx];
    ovf_nxt  = ovf_r[pidx];
    err_nxt  = err_r[pidx];
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    rd_ok    = 1'b0;
    txv      = 1'b0;
    st       = uadrb_pkg::ST_OK;
    case (uadrb_pkg::cmd_t'(item_r.command))
      uadrb_pkg::CMD_TX_WRITE: begin
        if (tx_f == TFW'(TX_DEPTH)) begin
          st = uadrb_pkg::ST_TX_FULL;
        end else begin
          tx_we    = 1'b1;
          tx_h_nxt = (tx_h == TPW'(TX_DEPTH - 1)) ? '0 : tx_h + TPW'(1);
          tx_f_nxt = tx_f + TFW'(1);
          irq_nxt  = 1'b1;
        end
      end
      uadrb_pkg::CMD_RX_READ: begin
        if (rx_f == '0) begin
          st = uadrb_pkg::ST_RX_EMPTY;
        end else begin
          rx_re    = 1'b1;
          rd_ok    = 1'b1;
          rx_t_nxt = (rx_t == RPW'(RX_DEPTH - 1)) ? '0 : rx_t + RPW'(1);
          rx_f_nxt = rx_f - RFW'(1);
        end
      end
      uadrb_pkg::CMD_LINE_RX: begin
        if (rx_f != RFW'(RX_DEPTH)) begin
          rx_we    = 1'b1;
          rx_h_nxt = (rx_h == RPW'(RX_DEPTH - 1)) ? '0 : rx_h + RPW'(1);
          rx_f_nxt = rx_f + RFW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      uadrb_pkg::CMD_LINE_TX: begin
        if (tx_f != '0) begin
          tx_re    = 1'b1;
          txv      = 1'b1;
          tx_t_nxt = (tx_t == TPW'(TX_DEPTH - 1)) ? '0 : tx_t + TPW'(1);
          tx_f_nxt = tx_f - TFW'(1);
        end else begin
          irq_nxt = 1'b0;
        end
      end
      uadrb_pkg::CMD_LINE_ERR: begin
        err_nxt = 1'b1;
      end
      uadrb_pkg::CMD_INIT: begin
        rx_h_nxt = '0;
        rx_t_nxt = '0;
        rx_f_nxt = '0;
        tx_h_nxt = '0;
        tx_t_nxt = '0;
        tx_f_nxt = '0;
        irq_nxt  = 1'b0;
        ovf_nxt  = 1'b0;
        err_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign do_upd = ctrl.exec && port_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        rx_head_r[p] <= '0;
        rx_tail_r[p] <= '0;
        rx_fill_r[p] <= '0;
        tx_head_r[p] <= '0;
        tx_tail_r[p] <= '0;
        tx_fill_r[p] <= '0;
        irq_r[p]     <= 1'b0;
        ovf_r[p]     <= 1'b0;
        err_r[p]     <= 1'b0;
      end
    end else if (do_upd) begin
      rx_head_r[pidx] <= rx_h_nxt;
      rx_tail_r[pidx] <= rx_t_nxt;
      rx_fill_r[pidx] <= rx_f_nxt;
      tx_head_r[pidx] <= tx_h_nxt;
      tx_tail_r[pidx] <= tx_t_nxt;
      tx_fill_r[pidx] <= tx_f_nxt;
      irq_r[pidx]     <= irq_nxt;
      ovf_r[pidx]     <= ovf_nxt;
      err_r[pidx]     <= err_nxt;
    end
  end

  // Each port owns a contiguous slice of each byte memory.
  always_comb begin
    rx_waddr = RAW'(32'(pidx) * RX_DEPTH + 32'(rx_h));
    rx_raddr = RAW'(32'(pidx) * RX_DEPTH + 32'(rx_t));
    tx_waddr = TAW'(32'(pidx) * TX_DEPTH + 32'(tx_h));
    tx_raddr = TAW'(32'(pidx) * TX_DEPTH + 32'(tx_t));
  end

  always_ff @(posedge clk) begin
    if (do_upd && rx_we) rx_mem[rx_waddr] <= item_r.data_byte;
    if (do_upd && rx_re) rx_q_r <= rx_mem[rx_raddr];
  end

  always_ff @(posedge clk) begin
    if (do_upd && tx_we) tx_mem[tx_waddr] <= item_r.data_byte;
    if (do_upd && tx_re) tx_q_r <= tx_mem[tx_raddr];
  end

  // Levels report the low five bits of the fill counts.
  always_comb begin
    rx_lvl_ext = {5'b0, rx_f_nxt};
    tx_lvl_ext = {5'b0, tx_f_nxt};
    res_nxt    = '0;
    if (port_ok) begin
      res_nxt.status_code      = st;
      res_nxt.line_tx_valid    = txv;
      res_nxt.tx_irq_on        = irq_nxt;
      res_nxt.rx_level         = rx_lvl_ext[4:0];
      res_nxt.tx_level         = tx_lvl_ext[4:0];
      res_nxt.rx_overflow_flag = ovf_nxt;
      res_nxt.line_error_flag  = err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (ctrl.exec) begin
      rd_ok_r <= rd_ok && port_ok;
    end
  end

  always_comb begin
    out_item              = res_r;
    out_item.read_byte    = rd_ok_r ? rx_q_r : '0;
    out_item.line_tx_byte = res_r.line_tx_valid ? tx_q_r : '0;
  end

endmodule

FILE: rtl/core/uart_dual_ring_buffer.sv
// Top level of the dual UART ring buffer block.
//
// The block keeps a receive ring and a transmit ring for each serial port,
// together with a transmit interrupt enable and two sticky flags per port.
// The input channel takes one item (command, port, data byte) at a rising
// edge where start is high and busy is low. Each item produces exactly one
// result, shown on out_item for a single cycle while out_valid is high.
// The receiver cannot hold results off, so the block never stalls on it.
// An item accepted at edge N executes in the following cycle and its
// result is shown in the cycle after that. Busy is high only in the execute
// cycle, and a new item may be accepted while the previous result is on
// display, so the block takes a new item before it is through with the last.
// The execute cycle is separate because the item is latched on acceptance,
// and the rings, the byte memory read port and the result register are only
// updated from the latched item at the end of the execute cycle.
// Reset is synchronous and active low; it clears all pointers, counts,
// flags and enables and returns the sequencer to idle. Ring contents are
// not cleared and need no clearing pass, since a slot is only read after
// it has been written.
module uart_dual_ring_buffer #(
  parameter int RX_DEPTH   = uadrb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH   = uadrb_pkg::TX_DEPTH_DEF,
  parameter int PORT_COUNT = uadrb_pkg::PORT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  uadrb_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output uadrb_pkg::out_item_t out_item
);

  `include "uart_dual_ring_buffer_assert.svh"

  uadrb_pkg::ctrl_t ctrl;

  // The sequencer decides when the datapath latches, executes and responds.
  uadrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // The datapath holds all ring state and builds the registered result.
  uadrb_dpath #(
    .RX_DEPTH   (RX_DEPTH),
    .TX_DEPTH   (TX_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // The result strobe is the response cycle of the sequencer.
  assign out_valid = ctrl.resp;

  // An accepted item is executing in the next cycle and is then answered in the response state.
  `UADRB_ASSERT_NXT(a_accept_exec, start && !busy, busy, "accepted item did not execute")
  `UADRB_ASSERT_NXT(a_accept_resp, start && !busy, ##1 out_valid, "accepted item got no result")
  // A refused host write can only come from a completely full transmit ring.
  `UADRB_ASSERT_IMP(a_full_level, out_valid && out_item.status_code == uadrb_pkg::ST_TX_FULL, out_item.tx_level == 5'(TX_DEPTH), "tx full reported below depth")
  // A read from an empty ring reports an empty ring and no byte.
  `UADRB_ASSERT_IMP(a_empty_read, out_valid && out_item.status_code == uadrb_pkg::ST_RX_EMPTY, out_item.rx_level == 5'd0 && out_item.read_byte == 8'd0, "rx empty with data")

endmodule

FILE: tb/uart_ring_checker.sv
// Watcher for the dual UART ring buffer: predicts every result and compares it.
module uart_ring_checker
  import uadrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      drain_done,
  output int        mismatch_count,
  output int        reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPORT = PORT_COUNT_DEF;
  localparam int RXD   = RX_DEPTH_DEF;
  localparam int TXD   = TX_DEPTH_DEF;

  // Port state as the block should hold it.
  logic [7:0]             rx_ring  [NPORT][RXD];
  logic [7:0]             tx_ring  [NPORT][TXD];
  logic [$clog2(RXD)-1:0] rx_wr    [NPORT];
  logic [$clog2(RXD)-1:0] rx_rd    [NPORT];
  logic [4:0]             rx_count [NPORT];
  logic [$clog2(TXD)-1:0] tx_wr    [NPORT];
  logic [$clog2(TXD)-1:0] tx_rd    [NPORT];
  logic [4:0]             tx_count [NPORT];
  logic                   tx_irq_en  [NPORT];
  logic                   rx_ovf     [NPORT];
  logic                   line_err   [NPORT];

  out_item_t port_reports_q[$];
  int        results_seen;
  bit        leftover_checked;

  initial begin
    mismatch_count = 0;
    reports_due = 0;
    results_seen = 0;
    leftover_checked = 1'b0;
  end

  task automatic note_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      note_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                              results_seen, name, got, want));
  endtask

  function automatic void clear_port(int p);
    rx_wr[p] = '0;
    rx_rd[p] = '0;
    rx_count[p] = '0;
    tx_wr[p] = '0;
    tx_rd[p] = '0;
    tx_count[p] = '0;
    tx_irq_en[p] = 1'b0;
    rx_ovf[p] = 1'b0;
    line_err[p] = 1'b0;
  endfunction

  // Applies one command to the port state and returns the report it causes.
  function automatic out_item_t step_ports(in_item_t item);
    out_item_t r;
    int p;
    r = '0;
    p = int'(item.port_sel);
    if (p >= NPORT) return r;
    case (item.command)
      CMD_TX_WRITE: begin
        if (tx_count[p] >= TXD) begin
          r.status_code = ST_TX_FULL;
        end else begin
          tx_ring[p][tx_wr[p]] = item.data_byte;
          tx_wr[p] = (int'(tx_wr[p]) == TXD - 1) ? '0 : tx_wr[p] + 1'b1;
          tx_count[p] = tx_count[p] + 1'b1;
          tx_irq_en[p] = 1'b1;
        end
      end
      CMD_RX_READ: begin
        if (rx_count[p] == 0) begin
          r.status_code = ST_RX_EMPTY;
        end else begin
          r.read_byte = rx_ring[p][rx_rd[p]];
          rx_rd[p] = (int'(rx_rd[p]) == RXD - 1) ? '0 : rx_rd[p] + 1'b1;
          rx_count[p] = rx_count[p] - 1'b1;
        end
      end
      CMD_LINE_RX: begin
        if (rx_count[p] < RXD) begin
          rx_ring[p][rx_wr[p]] = item.data_byte;
          rx_wr[p] = (int'(rx_wr[p]) == RXD - 1) ? '0 : rx_wr[p] + 1'b1;
          rx_count[p] = rx_count[p] + 1'b1;
        end else begin
          rx_ovf[p] = 1'b1;
        end
      end
      CMD_LINE_TX: begin
        // A queued byte goes out regardless of the interrupt enable.
        if (tx_count[p] != 0) begin
          r.line_tx_valid = 1'b1;
          r.line_tx_byte = tx_ring[p][tx_rd[p]];
          tx_rd[p] = (int'(tx_rd[p]) == TXD - 1) ? '0 : tx_rd[p] + 1'b1;
          tx_count[p] = tx_count[p] - 1'b1;
        end else begin
          tx_irq_en[p] = 1'b0;
        end
      end
      CMD_LINE_ERR: line_err[p] = 1'b1;
      CMD_INIT:     clear_port(p);
      default: ;
    endcase
    r.tx_irq_on = tx_irq_en[p];
    r.rx_level = rx_count[p];
    r.tx_level = tx_count[p];
    r.rx_overflow_flag = rx_ovf[p];
    r.line_error_flag = line_err[p];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int p = 0; p < NPORT; p++) clear_port(p);
      port_reports_q.delete();
    end else begin
      if ($isunknown(out_valid)) begin
        note_mismatch("out_valid is unknown");
      end else if (out_valid) begin
        if (port_reports_q.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with no item outstanding",
                                  results_seen));
        end else begin
          want = port_reports_q.pop_front();
          check_field("status_code", 8'(out_item.status_code), 8'(want.status_code));
          check_field("read_byte", out_item.read_byte, want.read_byte);
          check_field("line_tx_valid", 8'(out_item.line_tx_valid),
                      8'(want.line_tx_valid));
          check_field("line_tx_byte", out_item.line_tx_byte, want.line_tx_byte);
          check_field("tx_irq_on", 8'(out_item.tx_irq_on), 8'(want.tx_irq_on));
          check_field("rx_level", 8'(out_item.rx_level), 8'(want.rx_level));
          check_field("tx_level", 8'(out_item.tx_level), 8'(want.tx_level));
          check_field("rx_overflow_flag", 8'(out_item.rx_overflow_flag),
                      8'(want.rx_overflow_flag));
          check_field("line_error_flag", 8'(out_item.line_error_flag),
                      8'(want.line_error_flag));
        end
        results_seen++;
      end
      if (start === 1'b1 && busy === 1'b0)
        port_reports_q.push_back(step_ports(in_item));
      if (drain_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (port_reports_q.size() != 0)
          note_mismatch($sformatf("%0d results never arrived", port_reports_q.size()));
      end
    end
    reports_due = port_reports_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the dual UART ring buffer testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import uadrb_pkg::*;

  // The command field is three bits wide, but only six codes are defined.
  // The two spare codes must behave as a no-op that still reports status.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  // Roughly 1700 random items on top of the directed opening.
  localparam int RANDOM_ITEMS = 1700;
  // Extra settle cycles after the drain catch stray results.
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT = 200;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      drain_done;
  int        mismatch_count;
  int        reports_due;

  // When set, items are issued back to back with no idle cycles in between.
  bit steady;
  int items_sent;

  uart_dual_ring_buffer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  uart_ring_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .drain_done     (drain_done),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest legal run,
  // which is under 70 us even with the longest gap before every item.
  initial begin
    #500000;
    $display("Verification failed");
    $finish;
  end

  // Issues one item. An optional idle gap comes first, then start is held
  // high until an edge where busy is low, which is the edge that takes the
  // item. Start is only ever assigned once per time step, so back-to-back
  // items keep it high without a glitch.
  task automatic issue(logic [2:0] cmd, logic port, logic [7:0] data);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{command: cmd, port_sel: port, data_byte: data};
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    int  len;
    int  pick;
    int  target;
    logic       port;
    logic [2:0] cmd;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    drain_done <= 1'b0;
    items_sent = 0;
    steady = 1'b1;

    // Synchronous reset, held low at the start and never asserted again.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty rings on both sides, byte extremes through
    // both rings, sticky error, spare codes, and init of each port. The
    // first half runs back to back, the rest with random gaps.
    issue(CMD_RX_READ,  1'b0, 8'h00);  // host read of an empty receive ring
    issue(CMD_LINE_TX,  1'b1, 8'h00);  // tx ready with nothing queued
    issue(CMD_TX_WRITE, 1'b0, 8'h00);  // accepted write raises the irq enable
    issue(CMD_TX_WRITE, 1'b0, 8'hFF);
    issue(CMD_LINE_TX,  1'b0, 8'h00);
    issue(CMD_LINE_TX,  1'b0, 8'h00);
    issue(CMD_LINE_TX,  1'b0, 8'h00);  // ring now empty, irq enable drops
    issue(CMD_LINE_RX,  1'b1, 8'hFF);
    issue(CMD_LINE_RX,  1'b1, 8'h00);
    issue(CMD_RX_READ,  1'b1, 8'h00);
    issue(CMD_RX_READ,  1'b1, 8'h00);
    steady = 1'b0;
    issue(CMD_RX_READ,  1'b1, 8'h00);
    issue(CMD_LINE_ERR, 1'b0, 8'h00);  // error flag sticks until port 0 is initialised below
    issue(CMD_SPARE_A,  1'b0, 8'hAA);
    issue(CMD_SPARE_B,  1'b1, 8'h55);
    issue(CMD_TX_WRITE, 1'b1, 8'hA5);
    issue(CMD_LINE_ERR, 1'b1, 8'h00);
    issue(CMD_INIT,     1'b1, 8'h00);  // clears levels, flags and irq enable
    issue(CMD_LINE_TX,  1'b1, 8'h00);
    issue(CMD_INIT,     1'b0, 8'h00);
    issue(CMD_LINE_RX,  1'b0, 8'h5A);
    issue(CMD_RX_READ,  1'b0, 8'h00);

    // Random part, organized as bursts. Fill bursts run past the ring depth
    // often enough to hit the full cases, drain bursts run past empty, and
    // mixed bursts interleave everything on both ports. Some bursts run
    // with no idle cycles at all.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      port = 1'($urandom_range(0, 1));
      steady = ($urandom_range(0, 3) == 0);
      len = $urandom_range(4, 24);
      case ($urandom_range(0, 5))
        0: repeat (len) issue(CMD_TX_WRITE, port, 8'($urandom_range(0, 255)));
        1: repeat (len) issue(CMD_LINE_RX, port, 8'($urandom_range(0, 255)));
        2: repeat (len) issue(CMD_LINE_TX, port, 8'($urandom_range(0, 255)));
        3: repeat (len) issue(CMD_RX_READ, port, 8'($urandom_range(0, 255)));
        default: begin
          repeat (len) begin
            // Mostly ring traffic; errors, inits and spare codes are rare so
            // the rings still get a chance to fill up.
            pick = $urandom_range(0, 99);
            if (pick < 23)       cmd = CMD_TX_WRITE;
            else if (pick < 46)  cmd = CMD_RX_READ;
            else if (pick < 69)  cmd = CMD_LINE_RX;
            else if (pick < 92)  cmd = CMD_LINE_TX;
            else if (pick < 96)  cmd = CMD_LINE_ERR;
            else if (pick < 98)  cmd = CMD_INIT;
            else if (pick < 99)  cmd = CMD_SPARE_A;
            else                 cmd = CMD_SPARE_B;
            issue(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    start <= 1'b0;

    // Let every outstanding result come back, then a short settle window in
    // which any extra result would be flagged by the checker.
    for (int k = 0; k < DRAIN_LIMIT && reports_due != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
